// ----- sv/assert_macros.svh -----
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define COD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication
`define COD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

// ----- sv/cod_pkg.sv -----
// types and constants of the cursor outline dilation block
// used by cod_ctrl, cod_datapath and the top level; no dependencies
`timescale 1ns / 1ps

package cod_pkg;

	localparam int COORD_W    = 7;
	localparam int CHAN_W     = 8;
	localparam int PIXEL_W    = 4 * CHAN_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;
	localparam int NUM_PROBES = 9;
	localparam int PROBE_W    = 4;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_DATA_W-1:0] SIDE_RESET = 7'd64;

	localparam logic [PROBE_W-1:0] FIRST_PROBE = 4'd0;
	localparam logic [PROBE_W-1:0] LAST_PROBE  = 4'd8;

	// probe order: center first, then the eight neighbours
	localparam logic signed [1:0] PROBE_DX [NUM_PROBES] =
		'{2'sb00, 2'sb11, 2'sb00, 2'sb01, 2'sb11, 2'sb01, 2'sb11, 2'sb00, 2'sb01};
	localparam logic signed [1:0] PROBE_DY [NUM_PROBES] =
		'{2'sb00, 2'sb11, 2'sb11, 2'sb11, 2'sb00, 2'sb00, 2'sb01, 2'sb01, 2'sb01};

	localparam logic [CHAN_W-1:0] OPAQUE = 8'd255;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PROBE,
		ST_EMIT
	} ctrl_state_t;

	typedef struct packed {
		logic               accept;
		logic               probe;
		logic [PROBE_W-1:0] probe_idx;
		logic               emit;
	} dp_cmd_t;

	typedef struct packed {
		logic is_read;
		logic is_bad;
	} dp_status_t;

endpackage

// ----- sv/cod_ctrl.sv -----
// controller of the cursor outline dilation block: sequences the nine probes
// depends on cod_pkg
`timescale 1ns / 1ps

module cod_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  cod_pkg::dp_status_t status,
	output cod_pkg::dp_cmd_t    cmd,
	output logic                busy
);

	cod_pkg::ctrl_state_t state_q, state_d;
	logic [cod_pkg::PROBE_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cod_pkg::ST_IDLE;
			cnt_q   <= cod_pkg::FIRST_PROBE;
		end else begin
			state_q <= state_d;
			// count stays within the probe table, back to the first probe after the last
			if ((state_q == cod_pkg::ST_PROBE) && (cnt_q != cod_pkg::LAST_PROBE)) begin
				cnt_q <= cod_pkg::PROBE_W'(cnt_q + 1'b1);
			end else begin
				cnt_q <= cod_pkg::FIRST_PROBE;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cod_pkg::ST_IDLE: begin
				if (start && status.is_read) begin
					state_d = status.is_bad ? cod_pkg::ST_EMIT : cod_pkg::ST_PROBE;
				end
			end
			cod_pkg::ST_PROBE: begin
				if (cnt_q == cod_pkg::LAST_PROBE) begin
					state_d = cod_pkg::ST_EMIT;
				end
			end
			cod_pkg::ST_EMIT: begin
				state_d = cod_pkg::ST_IDLE;
			end
			default: begin
				state_d = cod_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.probe_idx = cnt_q;
		busy          = 1'b1;
		unique case (state_q)
			cod_pkg::ST_IDLE: begin
				busy       = 1'b0;
				cmd.accept = start;
			end
			cod_pkg::ST_PROBE: begin
				cmd.probe = 1'b1;
			end
			cod_pkg::ST_EMIT: begin
				cmd.emit = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// ----- sv/cod_datapath.sv -----
// datapath of the cursor outline dilation block: size registers, pixel memory,
// probe address generation, neighbour accumulation and result registers; depends on cod_pkg
`timescale 1ns / 1ps

module cod_datapath #(
	parameter int MAX_SIDE = 64
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cod_pkg::dp_cmd_t                    cmd,
	output cod_pkg::dp_status_t                 status,
	input  logic                                cfg_write,
	input  logic [cod_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [cod_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                action,
	input  logic [cod_pkg::COORD_W-1:0]         col,
	input  logic [cod_pkg::COORD_W-1:0]         row,
	input  logic [cod_pkg::CHAN_W-1:0]          red_in,
	input  logic [cod_pkg::CHAN_W-1:0]          green_in,
	input  logic [cod_pkg::CHAN_W-1:0]          blue_in,
	input  logic [cod_pkg::CHAN_W-1:0]          alpha_in,
	output logic                                done,
	output logic [cod_pkg::CHAN_W-1:0]          red_out,
	output logic [cod_pkg::CHAN_W-1:0]          green_out,
	output logic [cod_pkg::CHAN_W-1:0]          blue_out,
	output logic [cod_pkg::CHAN_W-1:0]          alpha_out,
	output logic                                bad_position
);

	localparam int AW     = $clog2(MAX_SIDE);
	localparam int ADDR_W = 2 * AW;
	localparam int DEPTH  = 2 ** ADDR_W;

	logic [cod_pkg::CFG_DATA_W-1:0] width_q, height_q;
	logic [8:0]                     w_eff, h_eff;

	logic [cod_pkg::COORD_W-1:0] col_q, row_q;
	logic                        bad_q;

	logic [cod_pkg::PIXEL_W-1:0] mem [DEPTH];
	logic                        wr_en;
	logic [ADDR_W-1:0]           wr_addr, rd_addr;

	logic signed [9:0] sc, sr;
	logic              probe_in;

	logic [cod_pkg::PIXEL_W-1:0] rd_data_s1;
	logic                        valid_s1, first_s1;

	logic [cod_pkg::PIXEL_W-1:0] self_q;
	logic                        inside_q, near_q;
	logic                        near_all;
	logic [cod_pkg::PIXEL_W-1:0] res;

	logic [cod_pkg::PIXEL_W-1:0] res_q;
	logic                        bad_out_q, done_q;

	// size registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= cod_pkg::SIDE_RESET;
			height_q <= cod_pkg::SIDE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				cod_pkg::REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				cod_pkg::REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sizes above the memory side clamp to it
	assign w_eff = ({2'b00, width_q} > 9'(MAX_SIDE)) ? 9'(MAX_SIDE) : {2'b00, width_q};
	assign h_eff = ({2'b00, height_q} > 9'(MAX_SIDE)) ? 9'(MAX_SIDE) : {2'b00, height_q};

	assign status.is_read = action;
	assign status.is_bad  = ({2'b00, col} >= 9'(w_eff + 9'd2)) ||
	                        ({2'b00, row} >= 9'(h_eff + 9'd2));

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			col_q <= col;
			row_q <= row;
			bad_q <= status.is_bad;
		end
	end

	// writes go straight into memory on acceptance
	assign wr_en   = cmd.accept && !action && ({2'b00, col} < w_eff) && ({2'b00, row} < h_eff);
	assign wr_addr = {AW'(row), AW'(col)};

	// probe position in source coordinates
	assign sc = $signed({3'b000, col_q}) + 10'(cod_pkg::PROBE_DX[cmd.probe_idx]) - 10'sd1;
	assign sr = $signed({3'b000, row_q}) + 10'(cod_pkg::PROBE_DY[cmd.probe_idx]) - 10'sd1;
	assign probe_in = !sc[9] && !sr[9] &&
	                  (sc < $signed({1'b0, w_eff})) && (sr < $signed({1'b0, h_eff}));
	assign rd_addr  = {sr[AW-1:0], sc[AW-1:0]};

	// writes only while idle, reads only while probing
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {alpha_in, blue_in, green_in, red_in};
		end
		if (cmd.probe) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
			inside_q <= 1'b0;
			near_q   <= 1'b0;
		end else begin
			valid_s1 <= cmd.probe && probe_in;
			first_s1 <= cmd.probe && (cmd.probe_idx == cod_pkg::FIRST_PROBE);
			if (cmd.accept) begin
				inside_q <= 1'b0;
				near_q   <= 1'b0;
			end else if (first_s1) begin
				inside_q <= valid_s1;
			end else begin
				near_q <= near_q || (valid_s1 && (rd_data_s1[31:24] != '0));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (first_s1) begin
			self_q <= rd_data_s1;
		end
	end

	// last neighbour lands during the emit cycle
	assign near_all = near_q || (valid_s1 && !first_s1 && (rd_data_s1[31:24] != '0));

	always_comb begin
		if (bad_q) begin
			res = '0;
		end else if (inside_q && (self_q[31:24] != '0)) begin
			res = self_q;
		end else if (near_all) begin
			res = {cod_pkg::OPAQUE, 24'h000000};
		end else if (inside_q) begin
			res = self_q;
		end else begin
			res = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			res_q     <= res;
			bad_out_q <= bad_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	assign done         = done_q;
	assign red_out      = res_q[7:0];
	assign green_out    = res_q[15:8];
	assign blue_out     = res_q[23:16];
	assign alpha_out    = res_q[31:24];
	assign bad_position = bad_out_q;

endmodule

// ----- sv/cursor_outline_dilation.sv -----
// top level of the cursor outline dilation block
// depends on cod_pkg, cod_ctrl, cod_datapath and assert_macros.svh
`timescale 1ns / 1ps

// stores an rgba cursor image and returns pixels of an outlined copy that is one
// pixel larger on every side: solid pixels pass, any other position next to a
// solid pixel reads opaque black. an item is taken when start is high and busy
// is low. a write item is stored on acceptance and busy never rises. a read item
// holds busy through nine probes of the pixel memory, center first, then one
// emit step, and its result shows on done once the emit step has registered it;
// a read outside the padded image skips the probes and goes straight to the emit
// step. done is high for exactly one cycle and the receiver cannot stall,
// so results must be taken when they appear. pixels must be written before they
// are read; the memory is not cleared at reset. the user must write the size
// registers only while idle; the block itself does not enforce it.
`include "assert_macros.svh"

module cursor_outline_dilation #(
	parameter int MAX_SIDE = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// item handshake
	input  logic                           start,
	output logic                           busy,
	// configuration
	input  logic                           cfg_write,
	input  logic [cod_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cod_pkg::CFG_DATA_W-1:0] cfg_data,
	// item fields
	input  logic                           action,
	input  logic [cod_pkg::COORD_W-1:0]    col,
	input  logic [cod_pkg::COORD_W-1:0]    row,
	input  logic [cod_pkg::CHAN_W-1:0]     red_in,
	input  logic [cod_pkg::CHAN_W-1:0]     green_in,
	input  logic [cod_pkg::CHAN_W-1:0]     blue_in,
	input  logic [cod_pkg::CHAN_W-1:0]     alpha_in,
	// result
	output logic                           done,
	output logic [cod_pkg::CHAN_W-1:0]     red_out,
	output logic [cod_pkg::CHAN_W-1:0]     green_out,
	output logic [cod_pkg::CHAN_W-1:0]     blue_out,
	output logic [cod_pkg::CHAN_W-1:0]     alpha_out,
	output logic                           bad_position
);

	// command and status between the sequencer and the datapath
	cod_pkg::dp_cmd_t    cmd;
	cod_pkg::dp_status_t status;

	// sequencer: idle, nine memory probes, emit
	cod_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// pixel memory, size registers, neighbour test and result registers
	cod_datapath #(
		.MAX_SIDE (MAX_SIDE)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.action       (action),
		.col          (col),
		.row          (row),
		.red_in       (red_in),
		.green_in     (green_in),
		.blue_in      (blue_in),
		.alpha_in     (alpha_in),
		.done         (done),
		.red_out      (red_out),
		.green_out    (green_out),
		.blue_out     (blue_out),
		.alpha_out    (alpha_out),
		.bad_position (bad_position)
	);

	// probes and the emit step only run while the block reports busy
	`COD_ASSERT_IMP(a_probe_busy, clk, arst_n, cmd.probe || cmd.emit, busy)
	// a write item never produces a result
	`COD_ASSERT_NEXT(a_write_silent, clk, arst_n, start && !busy && !action, !done)
	// a result strobe lasts one cycle
	`COD_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done)
	// an out-of-range read returns all channels zero
	`COD_ASSERT_IMP(a_bad_zero, clk, arst_n, done && bad_position, (red_out == '0) && (green_out == '0) && (blue_out == '0) && (alpha_out == '0))

endmodule
